@@ rtl/ycc420_pkg.sv @@
package ycc420_pkg;

  // field widths of the pixel and result beats
  localparam int PixW       = 8;
  localparam int LumaOffW   = 27;
  localparam int ChromaOffW = 24;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_LUMA_STRIDE  = 3'd2,
    CFG_BLUE_STRIDE  = 3'd3,
    CFG_RED_STRIDE   = 3'd4
  } cfg_idx_e;

  // register reset values
  localparam logic [12:0] FrameWidthRst  = 13'd640;
  localparam logic [12:0] FrameHeightRst = 13'd480;
  localparam logic [14:0] LumaStrideRst  = 15'd640;
  localparam logic [13:0] BlueStrideRst  = 14'd320;
  localparam logic [13:0] RedStrideRst   = 14'd320;

endpackage

@@ rtl/ycbcr444_to_420_subsampler.sv @@
// channel | valid       | stall       | payload
// pixel   | pix_valid_i | pix_stall_o | pix_luma_i, pix_blue_i, pix_red_i
// result  | res_valid_o | res_stall_i | luma_out_o .. frame_done_o (one per pixel)
// config  | cfg_we_i    | -           | cfg_index_i, cfg_data_i
//
// one pixel per cycle while the result side does not stall; three register stages (line
// store read, row offset multipliers, offset adders) lie between the pixel port and
// the result port
// the pair-sum line store has a registered read, written on even rows, read on odd rows
// reset and any register write restart the frame at row 0, column 0; no clearing pass
// a stalled result freezes the whole pipeline and pix_stall_o follows at once
module ycbcr444_to_420_subsampler #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [ycc420_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ycc420_pkg::CfgDataW-1:0]      cfg_data_i,
  // pixel beats
  input  logic                                 pix_valid_i,
  output logic                                 pix_stall_o,
  input  logic [ycc420_pkg::PixW-1:0]          pix_luma_i,
  input  logic [ycc420_pkg::PixW-1:0]          pix_blue_i,
  input  logic [ycc420_pkg::PixW-1:0]          pix_red_i,
  // result beats
  output logic                                 res_valid_o,
  input  logic                                 res_stall_i,
  output logic [ycc420_pkg::PixW-1:0]          luma_out_o,
  output logic [ycc420_pkg::LumaOffW-1:0]      luma_offset_o,
  output logic                                 chroma_valid_o,
  output logic [ycc420_pkg::PixW-1:0]          blue_avg_o,
  output logic [ycc420_pkg::PixW-1:0]          red_avg_o,
  output logic [ycc420_pkg::ChromaOffW-1:0]    blue_offset_o,
  output logic [ycc420_pkg::ChromaOffW-1:0]    red_offset_o,
  output logic                                 frame_done_o
);
  import ycc420_pkg::*;

  localparam int WEven     = int'(MAX_WIDTH) - (int'(MAX_WIDTH) % 2);
  localparam int WCap      = (WEven < 8190) ? WEven : 8190;
  localparam logic [12:0] WCapV = 13'(WCap);
  localparam int ColW      = $clog2(WCap);
  localparam int LineDepth = (WCap / 2 > 1) ? WCap / 2 : 1;
  localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;

  typedef struct packed {
    logic [PixW-1:0] luma;
    logic [ColW-1:0] col;
    logic [11:0]     lrow;
    logic [10:0]     crow;
    logic [8:0]      bpair;
    logic [8:0]      rpair;
    logic            chroma;
    logic            done;
  } s1_t;

  typedef struct packed {
    logic [PixW-1:0] luma;
    logic [ColW-1:0] col;
    logic [25:0]     lprod;
    logic [23:0]     bprod;
    logic [23:0]     rprod;
    logic [PixW-1:0] bavg;
    logic [PixW-1:0] ravg;
    logic            chroma;
    logic            done;
  } s2_t;

  // configuration registers
  logic [12:0] frame_width_q, frame_height_q;
  logic [14:0] luma_stride_q;
  logic [13:0] blue_stride_q, red_stride_q;
  logic        cfg_hit;

  assign cfg_hit = cfg_we_i && ((cfg_index_i == CFG_FRAME_WIDTH) ||
                   (cfg_index_i == CFG_FRAME_HEIGHT) || (cfg_index_i == CFG_LUMA_STRIDE) ||
                   (cfg_index_i == CFG_BLUE_STRIDE) || (cfg_index_i == CFG_RED_STRIDE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
      luma_stride_q  <= LumaStrideRst;
      blue_stride_q  <= BlueStrideRst;
      red_stride_q   <= RedStrideRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[12:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[12:0];
        CFG_LUMA_STRIDE:  luma_stride_q  <= cfg_data_i;
        CFG_BLUE_STRIDE:  blue_stride_q  <= cfg_data_i[13:0];
        CFG_RED_STRIDE:   red_stride_q   <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // effective even frame size
  logic [12:0] w_mask, h_mask, w_eff, h_eff;

  always_comb begin
    w_mask = frame_width_q & 13'h1FFE;
    h_mask = frame_height_q & 13'h1FFE;
    priority if (w_mask < 13'd2) w_eff = 13'd2;
    else if (w_mask > WCapV)     w_eff = WCapV;
    else                         w_eff = w_mask;
    priority if (h_mask < 13'd2)    h_eff = 13'd2;
    else if (h_mask > 13'd4096)     h_eff = 13'd4096;
    else                            h_eff = h_mask;
  end

  // pipeline advance
  logic out_valid_q, s1_valid_q, s2_valid_q;
  logic adv, accept;

  assign adv         = !(out_valid_q && res_stall_i);
  assign pix_stall_o = !adv;
  assign accept      = pix_valid_i && adv;

  // raster position
  logic [ColW-1:0] col_q;
  logic [11:0]     row_q;
  logic [PixW-1:0] pend_b_q, pend_r_q;
  logic            last_col, last_row, odd_col, odd_row;

  assign last_col = (13'(col_q) == (w_eff - 13'd1));
  assign last_row = ({1'b0, row_q} == (h_eff - 13'd1));
  assign odd_col  = col_q[0];
  assign odd_row  = row_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      pend_b_q <= '0;
      pend_r_q <= '0;
    end else if (cfg_hit) begin
      col_q    <= '0;
      row_q    <= '0;
      pend_b_q <= '0;
      pend_r_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? 12'd0 : row_q + 12'd1;
      end else begin
        col_q <= col_q + ColW'(1);
      end
      if (!odd_col) begin
        pend_b_q <= pix_blue_i;
        pend_r_q <= pix_red_i;
      end
    end
  end

  // horizontal pair sums
  logic [8:0] bpair, rpair;

  assign bpair = {1'b0, pend_b_q} + {1'b0, pix_blue_i};
  assign rpair = {1'b0, pend_r_q} + {1'b0, pix_red_i};

  // pair-sum line store
  logic [17:0]      line_mem [LineDepth];
  logic [17:0]      line_rd_q;
  logic [AddrW-1:0] line_addr;
  logic             line_we, line_re;

  assign line_addr = AddrW'(col_q >> 1);
  assign line_we   = accept && odd_col && !odd_row;
  assign line_re   = accept && odd_col && odd_row;

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[line_addr] <= {rpair, bpair};
    end
    if (line_re) begin
      line_rd_q <= line_mem[line_addr];
    end
  end

  // stage 1 load
  s1_t s1_d, s1_q;

  always_comb begin
    s1_d.luma   = pix_luma_i;
    s1_d.col    = col_q;
    s1_d.lrow   = 12'(h_eff - 13'd1 - {1'b0, row_q});
    s1_d.crow   = 11'(h_eff[12:1] - 12'd1 - {1'b0, row_q[11:1]});
    s1_d.bpair  = bpair;
    s1_d.rpair  = rpair;
    s1_d.chroma = odd_col && odd_row;
    s1_d.done   = last_col && last_row;
  end

  // stage 1: vertical sums, rounding, row offset products
  s2_t         s2_d, s2_q;
  logic [9:0]  bsum, rsum;
  logic [26:0] lprod_full;
  logic [24:0] bprod_full, rprod_full;

  always_comb begin
    bsum       = {1'b0, s1_q.bpair} + {1'b0, line_rd_q[8:0]} + 10'd2;
    rsum       = {1'b0, s1_q.rpair} + {1'b0, line_rd_q[17:9]} + 10'd2;
    lprod_full = {15'b0, s1_q.lrow} * {12'b0, luma_stride_q};
    bprod_full = {14'b0, s1_q.crow} * {11'b0, blue_stride_q};
    rprod_full = {14'b0, s1_q.crow} * {11'b0, red_stride_q};
    s2_d.luma   = s1_q.luma;
    s2_d.col    = s1_q.col;
    s2_d.lprod  = lprod_full[25:0];
    s2_d.bprod  = bprod_full[23:0];
    s2_d.rprod  = rprod_full[23:0];
    s2_d.bavg   = bsum[9:2];
    s2_d.ravg   = rsum[9:2];
    s2_d.chroma = s1_q.chroma;
    s2_d.done   = s1_q.done;
  end

  // stage 2: add column to the row offsets
  logic [LumaOffW-1:0]   luma_off_d;
  logic [ChromaOffW-1:0] blue_off_d, red_off_d;
  logic [ChromaOffW-1:0] half_col;

  always_comb begin
    half_col   = ChromaOffW'(s2_q.col >> 1);
    luma_off_d = {1'b0, s2_q.lprod} + LumaOffW'(s2_q.col);
    blue_off_d = s2_q.bprod + half_col;
    red_off_d  = s2_q.rprod + half_col;
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= pix_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q           <= s1_d;
      s2_q           <= s2_d;
      luma_out_o     <= s2_q.luma;
      luma_offset_o  <= luma_off_d;
      chroma_valid_o <= s2_q.chroma;
      blue_avg_o     <= s2_q.chroma ? s2_q.bavg : '0;
      red_avg_o      <= s2_q.chroma ? s2_q.ravg : '0;
      blue_offset_o  <= s2_q.chroma ? blue_off_d : '0;
      red_offset_o   <= s2_q.chroma ? red_off_d : '0;
      frame_done_o   <= s2_q.done;
    end
  end

  assign res_valid_o = out_valid_q;

endmodule

@@ rtl/ycc420_checker.sv @@
module ycc420_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              pix_valid_i,
  input logic                              pix_stall_o,
  input logic [ycc420_pkg::PixW-1:0]       pix_luma_i,
  input logic                              res_valid_o,
  input logic                              res_stall_i,
  input logic [ycc420_pkg::PixW-1:0]       luma_out_o,
  input logic [ycc420_pkg::LumaOffW-1:0]   luma_offset_o,
  input logic                              chroma_valid_o,
  input logic [ycc420_pkg::PixW-1:0]       blue_avg_o,
  input logic [ycc420_pkg::PixW-1:0]       red_avg_o,
  input logic [ycc420_pkg::ChromaOffW-1:0] blue_offset_o,
  input logic [ycc420_pkg::ChromaOffW-1:0] red_offset_o,
  input logic                              frame_done_o
);
  import ycc420_pkg::*;

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(luma_offset_o) &&
    $stable(luma_out_o) && $stable(chroma_valid_o))
    else $error("stalled result beat changed");

  // beats without a chroma sample carry zero chroma fields
  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !chroma_valid_o |-> blue_avg_o == '0 && red_avg_o == '0 &&
    blue_offset_o == '0 && red_offset_o == '0)
    else $error("chroma fields set without a chroma sample");

  // last pixel of a frame closes a 2x2 block
  a_done_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && frame_done_o |-> chroma_valid_o)
    else $error("frame end without a chroma sample");

  // an accepted pixel's luma reaches the result port when the result side keeps moving
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_i && !pix_stall_o) ##1 !res_stall_i ##1 !res_stall_i |=>
    res_valid_o && luma_out_o == $past(pix_luma_i, 3))
    else $error("luma beat lost or late");

endmodule

bind ycbcr444_to_420_subsampler ycc420_checker u_ycc420_checker (.*);
